// ----- hw/rtl/stpt_pkg.sv -----
// Shared types, constants and micro-op program of the scan-to-point transform.
package stpt_pkg;

	// Input item packing in tdata, lowest bit first.
	localparam int IN_W        = 168;
	localparam int IDX_LSB     = 0;
	localparam int COEF_LSB    = 5;
	localparam int START_LSB   = 37;
	localparam int STEP_LSB    = 69;
	localparam int MOTOR_LSB   = 101;
	localparam int RANGE_LSB   = 133;
	localparam int OUT_W       = 96;
	localparam int CFG_IDX_W   = 3;

	localparam int ANG_W  = 34;
	localparam int OPND_W = 33;
	localparam int PROD_W = 66;
	localparam int ACC_W  = 56;
	localparam int PC_W   = 6;

	localparam logic signed [ANG_W-1:0] PI_Q        = 34'sd843314857;
	localparam logic signed [ANG_W-1:0] TWO_PI_Q    = 34'sd1686629713;
	localparam logic signed [ANG_W-1:0] HALF_PI_Q   = 34'sd421657428;
	localparam logic signed [ANG_W-1:0] CORDIC_GAIN = 34'sd652032874;
	localparam int CORDIC_STEPS = 30;

	localparam logic signed [OPND_W-1:0] ONE_Q30 = 33'sd1073741824;
	localparam logic signed [OPND_W-1:0] ONE_Q16 = 33'sd65536;

	typedef enum logic [1:0] {
		OP_LOAD   = 2'd0,
		OP_START  = 2'd1,
		OP_SAMPLE = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RANGE_MIN = 3'd0,
		REG_RANGE_MAX = 3'd1,
		REG_AXIS_X    = 3'd2,
		REG_AXIS_Y    = 3'd3,
		REG_AXIS_Z    = 3'd4,
		REG_INC_ANGLE = 3'd5
	} cfg_reg_t;

	typedef enum logic [4:0] {
		OPD_ZERO, OPD_RNG, OPD_CB, OPD_SB, OPD_CM, OPD_SM, OPD_OMC,
		OPD_PL0, OPD_PL1, OPD_PM0, OPD_PM1, OPD_PM2,
		OPD_AX, OPD_AY, OPD_AZ, OPD_DOT, OPD_KK,
		OPD_CX, OPD_CY, OPD_CZ, OPD_PR0, OPD_PR1, OPD_PR2,
		OPD_COEF, OPD_ONE16
	} opnd_t;

	typedef enum logic [3:0] {
		DST_PL0, DST_PL1, DST_PM0, DST_PM1, DST_PM2, DST_DOT,
		DST_CX, DST_CY, DST_CZ, DST_KK, DST_PR0, DST_PR1, DST_PR2,
		DST_Q0, DST_Q1, DST_Q2
	} dst_t;

	typedef struct packed {
		opnd_t      a;
		opnd_t      b;
		logic       k30;
		logic       sub;
		logic       first;
		logic       wb;
		logic       last;
		dst_t       dst;
		logic [4:0] caddr;
	} uop_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_CHECK, ST_CORD_B, ST_CORD_M, ST_PROG, ST_DRAIN,
		ST_ADV, ST_WRAP_START, ST_WRAP_SAMPLE, ST_RESULT
	} state_t;

	typedef struct packed {
		logic       coef_wr;
		logic       start_load;
		logic       sample_load;
		logic       cordic_go;
		logic       cordic_sel;
		logic       issue;
		uop_t       uop;
		logic [4:0] coef_raddr;
		logic       advance;
		logic       wrap_step;
		logic       out_load;
	} ctrl_cmd_t;

	typedef struct packed {
		logic in_range;
		logic cordic_done;
		logic angles_ok;
		logic out_free;
	} dp_status_t;

	function automatic logic [31:0] atan_at(input logic [4:0] k);
		logic [31:0] r;
		case (k)
			5'd0: r = 32'd843314856;
			5'd1: r = 32'd497837829;
			5'd2: r = 32'd263043836;
			5'd3: r = 32'd133525158;
			5'd4: r = 32'd67021686;
			5'd5: r = 32'd33543515;
			5'd6: r = 32'd16775850;
			5'd7: r = 32'd8388437;
			5'd8: r = 32'd4194282;
			5'd9: r = 32'd2097149;
			5'd10: r = 32'd1048575;
			5'd11: r = 32'd524287;
			5'd12: r = 32'd262143;
			5'd13: r = 32'd131071;
			5'd14: r = 32'd65535;
			5'd15: r = 32'd32767;
			5'd16: r = 32'd16383;
			5'd17: r = 32'd8191;
			5'd18: r = 32'd4095;
			5'd19: r = 32'd2047;
			5'd20: r = 32'd1023;
			5'd21: r = 32'd511;
			5'd22: r = 32'd255;
			5'd23: r = 32'd127;
			5'd24: r = 32'd63;
			5'd25: r = 32'd31;
			5'd26: r = 32'd15;
			5'd27: r = 32'd7;
			5'd28: r = 32'd3;
			5'd29: r = 32'd1;
			default: r = 32'd0;
		endcase
		return r;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
		logic signed [31:0] r;
		if (v > 56'sd2147483647) r = 32'sh7FFFFFFF;
		else if (v < -56'sd2147483648) r = 32'sh80000000;
		else r = v[31:0];
		return r;
	endfunction

	function automatic uop_t mk(input opnd_t a, input opnd_t b, input logic k30,
			input logic sub, input logic first, input logic wb, input dst_t dst,
			input logic [4:0] caddr, input logic last);
		uop_t u;
		u.a = a; u.b = b; u.k30 = k30; u.sub = sub; u.first = first;
		u.wb = wb; u.dst = dst; u.caddr = caddr; u.last = last;
		return u;
	endfunction

	// Multiply-accumulate program for one in-range sample. A result written
	// back is read no earlier than two steps after the step that wrote it.
	function automatic uop_t uop_at(input logic [PC_W-1:0] pc);
		uop_t u;
		case (pc)
			// polar point in the scan plane
			6'd0:  u = mk(OPD_RNG, OPD_CB, 1'b1, 1'b0, 1'b1, 1'b1, DST_PL0, 5'd0, 1'b0);
			6'd1:  u = mk(OPD_RNG, OPD_SB, 1'b1, 1'b0, 1'b1, 1'b1, DST_PL1, 5'd0, 1'b0);
			// mount transform; the z term of the polar point is zero
			6'd2:  u = mk(OPD_COEF, OPD_ONE16, 1'b0, 1'b0, 1'b1, 1'b0, DST_PM0, 5'd3, 1'b0);
			6'd3:  u = mk(OPD_COEF, OPD_PL0, 1'b0, 1'b0, 1'b0, 1'b0, DST_PM0, 5'd0, 1'b0);
			6'd4:  u = mk(OPD_COEF, OPD_PL1, 1'b0, 1'b0, 1'b0, 1'b1, DST_PM0, 5'd1, 1'b0);
			6'd5:  u = mk(OPD_COEF, OPD_ONE16, 1'b0, 1'b0, 1'b1, 1'b0, DST_PM1, 5'd7, 1'b0);
			6'd6:  u = mk(OPD_COEF, OPD_PL0, 1'b0, 1'b0, 1'b0, 1'b0, DST_PM1, 5'd4, 1'b0);
			6'd7:  u = mk(OPD_COEF, OPD_PL1, 1'b0, 1'b0, 1'b0, 1'b1, DST_PM1, 5'd5, 1'b0);
			6'd8:  u = mk(OPD_COEF, OPD_ONE16, 1'b0, 1'b0, 1'b1, 1'b0, DST_PM2, 5'd11, 1'b0);
			6'd9:  u = mk(OPD_COEF, OPD_PL0, 1'b0, 1'b0, 1'b0, 1'b0, DST_PM2, 5'd8, 1'b0);
			6'd10: u = mk(OPD_COEF, OPD_PL1, 1'b0, 1'b0, 1'b0, 1'b1, DST_PM2, 5'd9, 1'b0);
			// dot and cross products with the motor axis, and the dot scaled by 1 - cos
			6'd11: u = mk(OPD_AX, OPD_PM0, 1'b1, 1'b0, 1'b1, 1'b0, DST_DOT, 5'd0, 1'b0);
			6'd12: u = mk(OPD_AY, OPD_PM1, 1'b1, 1'b0, 1'b0, 1'b0, DST_DOT, 5'd0, 1'b0);
			6'd13: u = mk(OPD_AZ, OPD_PM2, 1'b1, 1'b0, 1'b0, 1'b1, DST_DOT, 5'd0, 1'b0);
			6'd14: u = mk(OPD_AZ, OPD_PM0, 1'b1, 1'b0, 1'b1, 1'b0, DST_CY, 5'd0, 1'b0);
			6'd15: u = mk(OPD_AX, OPD_PM2, 1'b1, 1'b1, 1'b0, 1'b1, DST_CY, 5'd0, 1'b0);
			6'd16: u = mk(OPD_OMC, OPD_DOT, 1'b1, 1'b0, 1'b1, 1'b1, DST_KK, 5'd0, 1'b0);
			6'd17: u = mk(OPD_AY, OPD_PM2, 1'b1, 1'b0, 1'b1, 1'b0, DST_CX, 5'd0, 1'b0);
			6'd18: u = mk(OPD_AZ, OPD_PM1, 1'b1, 1'b1, 1'b0, 1'b1, DST_CX, 5'd0, 1'b0);
			6'd19: u = mk(OPD_AX, OPD_PM1, 1'b1, 1'b0, 1'b1, 1'b0, DST_CZ, 5'd0, 1'b0);
			6'd20: u = mk(OPD_AY, OPD_PM0, 1'b1, 1'b1, 1'b0, 1'b1, DST_CZ, 5'd0, 1'b0);
			// Rodrigues rotation
			6'd21: u = mk(OPD_PM0, OPD_CM, 1'b1, 1'b0, 1'b1, 1'b0, DST_PR0, 5'd0, 1'b0);
			6'd22: u = mk(OPD_CX, OPD_SM, 1'b1, 1'b0, 1'b0, 1'b0, DST_PR0, 5'd0, 1'b0);
			6'd23: u = mk(OPD_AX, OPD_KK, 1'b1, 1'b0, 1'b0, 1'b1, DST_PR0, 5'd0, 1'b0);
			6'd24: u = mk(OPD_PM1, OPD_CM, 1'b1, 1'b0, 1'b1, 1'b0, DST_PR1, 5'd0, 1'b0);
			6'd25: u = mk(OPD_CY, OPD_SM, 1'b1, 1'b0, 1'b0, 1'b0, DST_PR1, 5'd0, 1'b0);
			6'd26: u = mk(OPD_AY, OPD_KK, 1'b1, 1'b0, 1'b0, 1'b1, DST_PR1, 5'd0, 1'b0);
			6'd27: u = mk(OPD_PM2, OPD_CM, 1'b1, 1'b0, 1'b1, 1'b0, DST_PR2, 5'd0, 1'b0);
			6'd28: u = mk(OPD_CZ, OPD_SM, 1'b1, 1'b0, 1'b0, 1'b0, DST_PR2, 5'd0, 1'b0);
			6'd29: u = mk(OPD_AZ, OPD_KK, 1'b1, 1'b0, 1'b0, 1'b1, DST_PR2, 5'd0, 1'b0);
			// world transform
			6'd30: u = mk(OPD_COEF, OPD_ONE16, 1'b0, 1'b0, 1'b1, 1'b0, DST_Q0, 5'd15, 1'b0);
			6'd31: u = mk(OPD_COEF, OPD_PR0, 1'b0, 1'b0, 1'b0, 1'b0, DST_Q0, 5'd12, 1'b0);
			6'd32: u = mk(OPD_COEF, OPD_PR1, 1'b0, 1'b0, 1'b0, 1'b0, DST_Q0, 5'd13, 1'b0);
			6'd33: u = mk(OPD_COEF, OPD_PR2, 1'b0, 1'b0, 1'b0, 1'b1, DST_Q0, 5'd14, 1'b0);
			6'd34: u = mk(OPD_COEF, OPD_ONE16, 1'b0, 1'b0, 1'b1, 1'b0, DST_Q1, 5'd19, 1'b0);
			6'd35: u = mk(OPD_COEF, OPD_PR0, 1'b0, 1'b0, 1'b0, 1'b0, DST_Q1, 5'd16, 1'b0);
			6'd36: u = mk(OPD_COEF, OPD_PR1, 1'b0, 1'b0, 1'b0, 1'b0, DST_Q1, 5'd17, 1'b0);
			6'd37: u = mk(OPD_COEF, OPD_PR2, 1'b0, 1'b0, 1'b0, 1'b1, DST_Q1, 5'd18, 1'b0);
			6'd38: u = mk(OPD_COEF, OPD_ONE16, 1'b0, 1'b0, 1'b1, 1'b0, DST_Q2, 5'd23, 1'b0);
			6'd39: u = mk(OPD_COEF, OPD_PR0, 1'b0, 1'b0, 1'b0, 1'b0, DST_Q2, 5'd20, 1'b0);
			6'd40: u = mk(OPD_COEF, OPD_PR1, 1'b0, 1'b0, 1'b0, 1'b0, DST_Q2, 5'd21, 1'b0);
			6'd41: u = mk(OPD_COEF, OPD_PR2, 1'b0, 1'b0, 1'b0, 1'b1, DST_Q2, 5'd22, 1'b1);
			default: u = mk(OPD_ZERO, OPD_ZERO, 1'b0, 1'b0, 1'b1, 1'b0, DST_PL0, 5'd0, 1'b1);
		endcase
		return u;
	endfunction

endpackage

// ----- hw/rtl/stpt_cordic.sv -----
// Serial rotation-mode CORDIC giving cosine and sine of an angle, one step per cycle.
module stpt_cordic import stpt_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     go,
	input  logic signed [ANG_W-1:0]  theta,
	output logic                     done,
	output logic signed [OPND_W-1:0] cos_val,
	output logic signed [OPND_W-1:0] sin_val
);

	localparam logic [4:0] STEP_LAST = 5'(CORDIC_STEPS - 1);

	logic signed [ANG_W-1:0] x_q, y_q, z_q;
	logic [4:0]              k_q;
	logic                    busy_q, neg_q, done_q;
	logic signed [ANG_W-1:0] th_red, atan_v;
	logic                    neg_c;

	// Fold the angle into the right half plane; the sign is restored at the end.
	always_comb begin
		neg_c  = 1'b0;
		th_red = theta;
		if (theta > HALF_PI_Q) begin
			th_red = theta - PI_Q;
			neg_c  = 1'b1;
		end else if (theta < -HALF_PI_Q) begin
			th_red = theta + PI_Q;
			neg_c  = 1'b1;
		end
		atan_v = signed'({2'b00, atan_at(k_q)});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			neg_q  <= 1'b0;
			done_q <= 1'b0;
			k_q    <= '0;
		end else begin
			done_q <= busy_q && (k_q == STEP_LAST) && !go;
			if (go) begin
				busy_q <= 1'b1;
				neg_q  <= neg_c;
				k_q    <= '0;
			end else if (busy_q) begin
				if (k_q == STEP_LAST) busy_q <= 1'b0;
				k_q <= k_q + 5'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			x_q <= CORDIC_GAIN;
			y_q <= '0;
			z_q <= th_red <<< 2;
		end else if (busy_q) begin
			if (z_q >= 0) begin
				x_q <= x_q - (y_q >>> k_q);
				y_q <= y_q + (x_q >>> k_q);
				z_q <= z_q - atan_v;
			end else begin
				x_q <= x_q + (y_q >>> k_q);
				y_q <= y_q - (x_q >>> k_q);
				z_q <= z_q + atan_v;
			end
		end
	end

	assign done    = done_q;
	assign cos_val = OPND_W'(neg_q ? -x_q : x_q);
	assign sin_val = OPND_W'(neg_q ? -y_q : y_q);

endmodule

// ----- hw/rtl/stpt_datapath.sv -----
// Datapath: registers, coefficient memory, angle unit, CORDIC and shared multiply-accumulate.
module stpt_datapath import stpt_pkg::*; #(
	parameter int COEF_DEPTH = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data,
	input  logic [IN_W-1:0]      in_data,
	input  logic                 in_last,
	input  ctrl_cmd_t            cmd,
	output dp_status_t           status,
	input  logic                 out_ready,
	output logic                 out_valid,
	output logic [OUT_W-1:0]     out_data,
	output logic                 out_flag,
	output logic                 out_last
);

	localparam int AW = $clog2(COEF_DEPTH);
	localparam logic signed [PROD_W-1:0] HALF30 = 66'sd536870912;
	localparam logic signed [PROD_W-1:0] HALF16 = 66'sd32768;

	logic [31:0] coef_mem [COEF_DEPTH];
	logic signed [31:0] coef_rd_q;

	logic [31:0] range_min_q, range_max_q;
	logic signed [31:0] axis_x_q, axis_y_q, axis_z_q, inc_q;

	logic signed [ANG_W-1:0] beam_q, motor_q;
	logic signed [31:0]      step_q;
	logic [31:0]             rng_q;
	logic                    last_q;

	logic signed [OPND_W-1:0] cb_q, sb_q, cm_q, sm_q;
	logic signed [31:0] pl0_q, pl1_q, pm0_q, pm1_q, pm2_q, dot_q, kk_q;
	logic signed [31:0] cx_q, cy_q, cz_q, pr0_q, pr1_q, pr2_q, q0_q, q1_q, q2_q;

	logic                     sel_q, cdone;
	logic signed [OPND_W-1:0] c_cos, c_sin;

	logic signed [OPND_W-1:0] a_val, b_val;
	logic signed [PROD_W-1:0] prod_s1, rnd, shf;
	uop_t                     uop_s1;
	logic                     issue_s1;
	logic signed [ACC_W-1:0]  acc_q, acc_base, term, acc_next;
	logic signed [31:0]       wb_val;

	logic [4:0]  in_idx;
	logic        in_range;
	logic        out_valid_q, out_flag_q, out_last_q;
	logic [OUT_W-1:0] out_data_q;

	assign in_idx   = in_data[IDX_LSB +: 5];
	assign in_range = (rng_q >= range_min_q) && (rng_q <= range_max_q);

	// Coefficient store: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (cmd.coef_wr && (int'(in_idx) < COEF_DEPTH))
			coef_mem[AW'(in_idx)] <= in_data[COEF_LSB +: 32];
		coef_rd_q <= coef_mem[AW'(cmd.coef_raddr)];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_min_q <= '0;
			range_max_q <= '1;
			axis_x_q    <= 32'sh40000000;
			axis_y_q    <= '0;
			axis_z_q    <= '0;
			inc_q       <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_RANGE_MIN: range_min_q <= cfg_data;
				REG_RANGE_MAX: range_max_q <= cfg_data;
				REG_AXIS_X:    axis_x_q    <= cfg_data;
				REG_AXIS_Y:    axis_y_q    <= cfg_data;
				REG_AXIS_Z:    axis_z_q    <= cfg_data;
				REG_INC_ANGLE: inc_q       <= cfg_data;
				default: ;
			endcase
		end
	end

	// Scan angles, kept in [-pi, pi) by one add or subtract of 2pi per step.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beam_q  <= '0;
			motor_q <= '0;
			step_q  <= '0;
		end else if (cmd.start_load) begin
			beam_q  <= ANG_W'($signed(in_data[START_LSB +: 32]));
			step_q  <= in_data[STEP_LSB +: 32];
			motor_q <= ANG_W'($signed(in_data[MOTOR_LSB +: 32]));
		end else if (cmd.advance) begin
			beam_q  <= beam_q + ANG_W'(step_q);
			motor_q <= motor_q + ANG_W'(inc_q);
		end else if (cmd.wrap_step) begin
			if (beam_q >= PI_Q) beam_q <= beam_q - TWO_PI_Q;
			else if (beam_q < -PI_Q) beam_q <= beam_q + TWO_PI_Q;
			if (motor_q >= PI_Q) motor_q <= motor_q - TWO_PI_Q;
			else if (motor_q < -PI_Q) motor_q <= motor_q + TWO_PI_Q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sample_load) begin
			rng_q  <= in_data[RANGE_LSB +: 32];
			last_q <= in_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) sel_q <= 1'b0;
		else if (cmd.cordic_go) sel_q <= cmd.cordic_sel;
	end

	stpt_cordic u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.go      (cmd.cordic_go),
		.theta   (cmd.cordic_sel ? motor_q : beam_q),
		.done    (cdone),
		.cos_val (c_cos),
		.sin_val (c_sin)
	);

	always_ff @(posedge clk) begin
		if (cdone) begin
			if (sel_q) begin
				cm_q <= c_cos;
				sm_q <= c_sin;
			end else begin
				cb_q <= c_cos;
				sb_q <= c_sin;
			end
		end
	end

	function automatic logic signed [OPND_W-1:0] opnd_val(input opnd_t s);
		logic signed [OPND_W-1:0] v;
		case (s)
			OPD_RNG:   v = signed'({1'b0, rng_q});
			OPD_CB:    v = cb_q;
			OPD_SB:    v = sb_q;
			OPD_CM:    v = cm_q;
			OPD_SM:    v = sm_q;
			OPD_OMC:   v = ONE_Q30 - cm_q;
			OPD_PL0:   v = OPND_W'(pl0_q);
			OPD_PL1:   v = OPND_W'(pl1_q);
			OPD_PM0:   v = OPND_W'(pm0_q);
			OPD_PM1:   v = OPND_W'(pm1_q);
			OPD_PM2:   v = OPND_W'(pm2_q);
			OPD_AX:    v = OPND_W'(axis_x_q);
			OPD_AY:    v = OPND_W'(axis_y_q);
			OPD_AZ:    v = OPND_W'(axis_z_q);
			OPD_DOT:   v = OPND_W'(dot_q);
			OPD_KK:    v = OPND_W'(kk_q);
			OPD_CX:    v = OPND_W'(cx_q);
			OPD_CY:    v = OPND_W'(cy_q);
			OPD_CZ:    v = OPND_W'(cz_q);
			OPD_PR0:   v = OPND_W'(pr0_q);
			OPD_PR1:   v = OPND_W'(pr1_q);
			OPD_PR2:   v = OPND_W'(pr2_q);
			OPD_COEF:  v = OPND_W'(coef_rd_q);
			OPD_ONE16: v = ONE_Q16;
			default:   v = '0;
		endcase
		return v;
	endfunction

	always_comb begin
		a_val = opnd_val(cmd.uop.a);
		b_val = opnd_val(cmd.uop.b);
	end

	// Stage 1: one 33x33 product per cycle.
	always_ff @(posedge clk) begin
		prod_s1 <= a_val * b_val;
		uop_s1  <= cmd.uop;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) issue_s1 <= 1'b0;
		else issue_s1 <= cmd.issue;
	end

	// Stage 2: round half up, scale, accumulate and optionally saturate back.
	always_comb begin
		rnd      = prod_s1 + (uop_s1.k30 ? HALF30 : HALF16);
		shf      = uop_s1.k30 ? (rnd >>> 30) : (rnd >>> 16);
		term     = ACC_W'(shf);
		acc_base = uop_s1.first ? '0 : acc_q;
		acc_next = uop_s1.sub ? (acc_base - term) : (acc_base + term);
		wb_val   = sat32(acc_next);
	end

	always_ff @(posedge clk) begin
		if (issue_s1) begin
			acc_q <= acc_next;
			if (uop_s1.wb) begin
				case (uop_s1.dst)
					DST_PL0: pl0_q <= wb_val;
					DST_PL1: pl1_q <= wb_val;
					DST_PM0: pm0_q <= wb_val;
					DST_PM1: pm1_q <= wb_val;
					DST_PM2: pm2_q <= wb_val;
					DST_DOT: dot_q <= wb_val;
					DST_CX:  cx_q  <= wb_val;
					DST_CY:  cy_q  <= wb_val;
					DST_CZ:  cz_q  <= wb_val;
					DST_KK:  kk_q  <= wb_val;
					DST_PR0: pr0_q <= wb_val;
					DST_PR1: pr1_q <= wb_val;
					DST_PR2: pr2_q <= wb_val;
					DST_Q0:  q0_q  <= wb_val;
					DST_Q1:  q1_q  <= wb_val;
					DST_Q2:  q2_q  <= wb_val;
					default: ;
				endcase
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (cmd.out_load) out_valid_q <= 1'b1;
		else if (out_ready) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_data_q <= in_range ? {q2_q, q1_q, q0_q} : '0;
			out_flag_q <= in_range;
			out_last_q <= last_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign out_flag  = out_flag_q;
	assign out_last  = out_last_q;

	always_comb begin
		status.in_range    = in_range;
		status.cordic_done = cdone;
		status.angles_ok   = (beam_q >= -PI_Q) && (beam_q < PI_Q) &&
		                     (motor_q >= -PI_Q) && (motor_q < PI_Q);
		status.out_free    = !out_valid_q || out_ready;
	end

endmodule

// ----- hw/rtl/stpt_ctrl.sv -----
// Controller: sequences each input item through the datapath.
module stpt_ctrl import stpt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [1:0] in_op,
	output logic       in_ready,
	input  dp_status_t status,
	output ctrl_cmd_t  cmd
);

	state_t           state_q, state_d;
	logic [PC_W-1:0]  pc_q, pc_d;
	logic             accept;
	uop_t             cur_uop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pc_q    <= '0;
		end else begin
			state_q <= state_d;
			pc_q    <= pc_d;
		end
	end

	assign cur_uop = uop_at(pc_q);

	always_comb begin
		state_d        = state_q;
		pc_d           = pc_q;
		in_ready       = 1'b0;
		accept         = 1'b0;
		cmd            = '0;
		cmd.uop        = cur_uop;
		cmd.coef_raddr = uop_at('0).caddr;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				accept   = in_valid;
				if (accept) begin
					case (op_t'(in_op))
						OP_LOAD:   cmd.coef_wr = 1'b1;
						OP_START: begin
							cmd.start_load = 1'b1;
							state_d        = ST_WRAP_START;
						end
						OP_SAMPLE: begin
							cmd.sample_load = 1'b1;
							state_d         = ST_CHECK;
						end
						default: ;
					endcase
				end
			end
			ST_CHECK: begin
				if (status.in_range) begin
					cmd.cordic_go  = 1'b1;
					cmd.cordic_sel = 1'b0;
					state_d        = ST_CORD_B;
				end else begin
					state_d = ST_ADV;
				end
			end
			ST_CORD_B: begin
				if (status.cordic_done) begin
					cmd.cordic_go  = 1'b1;
					cmd.cordic_sel = 1'b1;
					state_d        = ST_CORD_M;
				end
			end
			ST_CORD_M: begin
				if (status.cordic_done) begin
					pc_d    = '0;
					state_d = ST_PROG;
				end
			end
			ST_PROG: begin
				cmd.issue      = 1'b1;
				cmd.coef_raddr = uop_at(pc_q + PC_W'(1)).caddr;
				pc_d           = pc_q + PC_W'(1);
				if (cur_uop.last) state_d = ST_DRAIN;
			end
			ST_DRAIN: state_d = ST_ADV;
			ST_ADV: begin
				cmd.advance = 1'b1;
				state_d     = ST_WRAP_SAMPLE;
			end
			ST_WRAP_START: begin
				if (status.angles_ok) state_d = ST_IDLE;
				else cmd.wrap_step = 1'b1;
			end
			ST_WRAP_SAMPLE: begin
				if (status.angles_ok) state_d = ST_RESULT;
				else cmd.wrap_step = 1'b1;
			end
			ST_RESULT: begin
				if (status.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

// ----- hw/rtl/scan_to_point_transform_unit.sv -----
// Top level of the scan-to-point transform: controller, datapath and ports.
//
// Turns laser range samples into 3-D world points. Items arrive on the s_axis
// channel; tuser carries the operation (load coefficient, start scan, range
// sample) and tlast marks the last sample of a scan. A load item writes one
// coefficient of the mount or world transform. A start item sets the beam
// and motor angles and the angle step, then folds the angles into [-pi, pi).
// A range sample gives exactly one point on m_axis: x, y, z in tdata, the
// in-range flag in tuser and the scan end in tlast. An in-range sample goes
// through two serial CORDIC passes for the beam and motor angles, 42
// multiply-accumulate steps on the single shared 33x33 multiplier, a drain
// step, an angle advance, the angle fold and the output load; then its point
// is offered and the next item can be taken. An out-of-range sample skips
// the CORDIC passes and the program, still advances the angles and yields a
// zero point with the flag cleared. One item is in work at a time;
// s_axis_tready is high only when the block is idle. Results sit in an
// output register, so a stalled receiver holds up the block only when a
// second point is ready before the first was taken. Reset clears the angles
// and loads the register defaults; coefficients are undefined until loaded.
// Configuration writes are taken at any edge.
module scan_to_point_transform_unit import stpt_pkg::*; #(
	parameter int COEF_DEPTH = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	// coef_index, coef_value, start_angle, angle_step, motor_angle, range, 3 pad bits
	input  logic [IN_W-1:0]      s_axis_tdata,
	// operation
	input  logic [1:0]           s_axis_tuser,
	input  logic                 s_axis_tlast,
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	// point_x, point_y, point_z
	output logic [OUT_W-1:0]     m_axis_tdata,
	// point_valid
	output logic [0:0]           m_axis_tuser,
	output logic                 m_axis_tlast
);

	ctrl_cmd_t  cmd;
	dp_status_t status;

	stpt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_op    (s_axis_tuser),
		.in_ready (s_axis_tready),
		.status   (status),
		.cmd      (cmd)
	);

	stpt_datapath #(
		.COEF_DEPTH (COEF_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (s_axis_tdata),
		.in_last   (s_axis_tlast),
		.cmd       (cmd),
		.status    (status),
		.out_ready (m_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_data  (m_axis_tdata),
		.out_flag  (m_axis_tuser[0]),
		.out_last  (m_axis_tlast)
	);

endmodule

// ----- hw/rtl/stpt_checker.sv -----
// Port-level checks of the scan-to-point transform, bound to the top level.
module stpt_checker import stpt_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_axis_tvalid,
	input logic                 s_axis_tready,
	input logic [1:0]           s_axis_tuser,
	input logic                 m_axis_tvalid,
	input logic                 m_axis_tready,
	input logic [OUT_W-1:0]     m_axis_tdata,
	input logic [0:0]           m_axis_tuser
);

	// A stalled point stays offered.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("point dropped while stalled");

	// A stalled point keeps its coordinates.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("point changed while stalled");

	// An out-of-range sample leaves a zero point.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == '0)
		else $error("rejected sample gave a nonzero point");

	// A range sample keeps the block busy for at least the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tuser == OP_SAMPLE |=> !s_axis_tready)
		else $error("sample accepted without work");

	// A coefficient load leaves the input ready again in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tuser == OP_LOAD |=> s_axis_tready)
		else $error("coefficient load stalled the input");

endmodule

bind scan_to_point_transform_unit stpt_checker u_stpt_checker (.*);

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for the scan-to-point transform unit.
`timescale 1ns / 100ps

module testbench;
	import stpt_pkg::*;

	localparam int    CLK_HALF   = 6;
	localparam int    SETTLE     = 150;
	localparam int    ITEM_GOAL  = 1650;
	localparam longint PI_C      = 843314857;
	localparam longint TWO_PI_C  = 1686629713;
	localparam longint HALF_PI_C = 421657428;
	localparam longint GAIN_C    = 652032874;
	localparam longint ONE30     = 1073741824;
	localparam longint ATAN_C [30] = '{
		843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
		16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143, 131071,
		65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255, 127, 63, 31,
		15, 7, 3, 1};

	typedef struct {
		op_t         op;
		logic [4:0]  idx;
		logic [31:0] cval;
		logic [31:0] start_ang;
		logic [31:0] step_ang;
		logic [31:0] motor_ang;
		logic [31:0] rng;
		logic        last;
	} scan_item_t;

	typedef struct {
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] z;
		logic        valid;
		logic        last;
	} point_t;

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [31:0]       cfg_data;
	logic              s_axis_tvalid;
	logic              s_axis_tready;
	logic [IN_W-1:0]   s_axis_tdata;
	logic [1:0]        s_axis_tuser;
	logic              s_axis_tlast;
	logic              m_axis_tvalid;
	logic              m_axis_tready;
	logic [OUT_W-1:0]  m_axis_tdata;
	logic [0:0]        m_axis_tuser;
	logic              m_axis_tlast;

	scan_to_point_transform_unit i_dut (.*);

	// Predictor state: our own copy of the coefficients, angles and registers.
	logic [31:0] coef_mem [32];
	longint      beam_ang, beam_inc, motor_ang;
	logic [31:0] lim_min, lim_max, ax_r, ay_r, az_r, inc_r;

	point_t expected_points [$];
	int     errors;
	int     items_sent;
	int     burst_left;

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	initial begin
		#40ms;
		$display("FAILURE");
		$finish;
	end

	function automatic longint sx(input logic [31:0] v);
		return longint'($signed(v));
	endfunction

	function automatic longint mulr(input longint a, input longint b, input int k);
		return (a * b + (longint'(1) << (k - 1))) >>> k;
	endfunction

	function automatic longint sat(input longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	// Folds an angle into [-pi, pi); % truncates toward zero, hence the fix-up.
	function automatic longint fold_angle(input longint v);
		longint r;
		r = (v + PI_C) % TWO_PI_C;
		if (r < 0) r += TWO_PI_C;
		return r - PI_C;
	endfunction

	// Rotation-mode CORDIC; angles beyond +-pi/2 are moved by pi and the result negated.
	function automatic void cordic_sincos(input longint theta, output longint c,
			output longint s);
		bit     neg;
		longint x, y, z, nx;
		neg = 0;
		x = GAIN_C;
		y = 0;
		if (theta > HALF_PI_C) begin
			theta -= PI_C;
			neg = 1;
		end else if (theta < -HALF_PI_C) begin
			theta += PI_C;
			neg = 1;
		end
		z = theta * 4;
		for (int k = 0; k < 30; k++) begin
			if (z >= 0) begin
				nx = x - (y >>> k);
				y = y + (x >>> k);
				z -= ATAN_C[k];
			end else begin
				nx = x + (y >>> k);
				y = y - (x >>> k);
				z += ATAN_C[k];
			end
			x = nx;
		end
		c = neg ? -x : x;
		s = neg ? -y : y;
	endfunction

	function automatic void apply_affine(input int base, input longint p [3],
			output longint q [3]);
		longint acc;
		for (int r = 0; r < 3; r++) begin
			acc = sx(coef_mem[base + r * 4 + 3]);
			for (int j = 0; j < 3; j++)
				acc += mulr(sx(coef_mem[base + r * 4 + j]), p[j], 16);
			q[r] = sat(acc);
		end
	endfunction

	// Beam angle places the sample in the scan plane, then mount transform,
	// Rodrigues rotation about the motor axis and world transform.
	function automatic point_t predict_point(input logic [31:0] rng, input logic last);
		point_t pt;
		longint cb, sb, cm, sm, ax, ay, az, dot, kk, cx, cy, cz;
		longint pl [3], pm [3], pr [3], res [3];
		pt.valid = (rng >= lim_min) && (rng <= lim_max);
		pt.last = last;
		res = '{0, 0, 0};
		if (pt.valid) begin
			cordic_sincos(beam_ang, cb, sb);
			pl[0] = sat(mulr(longint'(rng), cb, 30));
			pl[1] = sat(mulr(longint'(rng), sb, 30));
			pl[2] = 0;
			apply_affine(0, pl, pm);
			cordic_sincos(motor_ang, cm, sm);
			ax = sx(ax_r);
			ay = sx(ay_r);
			az = sx(az_r);
			dot = sat(mulr(ax, pm[0], 30) + mulr(ay, pm[1], 30) + mulr(az, pm[2], 30));
			cx = sat(mulr(ay, pm[2], 30) - mulr(az, pm[1], 30));
			cy = sat(mulr(az, pm[0], 30) - mulr(ax, pm[2], 30));
			cz = sat(mulr(ax, pm[1], 30) - mulr(ay, pm[0], 30));
			kk = sat(mulr(ONE30 - cm, dot, 30));
			pr[0] = sat(mulr(pm[0], cm, 30) + mulr(cx, sm, 30) + mulr(ax, kk, 30));
			pr[1] = sat(mulr(pm[1], cm, 30) + mulr(cy, sm, 30) + mulr(ay, kk, 30));
			pr[2] = sat(mulr(pm[2], cm, 30) + mulr(cz, sm, 30) + mulr(az, kk, 30));
			apply_affine(12, pr, res);
		end
		// Both angles advance whether or not the sample was in range.
		beam_ang = fold_angle(beam_ang + beam_inc);
		motor_ang = fold_angle(motor_ang + sx(inc_r));
		pt.x = res[0][31:0];
		pt.y = res[1][31:0];
		pt.z = res[2][31:0];
		return pt;
	endfunction

	// Updates the predictor for one accepted item.
	function automatic void track_item(input scan_item_t it);
		case (it.op)
			OP_LOAD: coef_mem[it.idx] = it.cval;
			OP_START: begin
				beam_ang = fold_angle(sx(it.start_ang));
				beam_inc = sx(it.step_ang);
				motor_ang = fold_angle(sx(it.motor_ang));
			end
			OP_SAMPLE: expected_points.push_back(predict_point(it.rng, it.last));
			default: ;
		endcase
	endfunction

	// Random item with every field filled, so that all bits toggle even in
	// fields that this operation ignores.
	function automatic scan_item_t noise_item(input op_t op);
		scan_item_t it;
		it.op = op;
		it.idx = 5'($urandom_range(0, 31));
		it.cval = $urandom;
		it.start_ang = $urandom;
		it.step_ang = $urandom;
		it.motor_ang = $urandom;
		it.rng = $urandom;
		it.last = 1'($urandom_range(0, 1));
		return it;
	endfunction

	// Bursty sender: valid stays high within a burst and drops for a gap.
	task automatic send_item(input scan_item_t it);
		if (burst_left == 0) begin
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = $urandom_range(1, 24);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {3'b000, it.rng, it.motor_ang, it.step_ang, it.start_ang,
			it.cval, it.idx};
		s_axis_tuser <= it.op;
		s_axis_tlast <= it.last;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		track_item(it);
		items_sent++;
		burst_left--;
		if (burst_left == 0) s_axis_tvalid <= 1'b0;
	endtask

	// Valid is still high only while a burst is open.
	task automatic stop_stream();
		if (burst_left != 0) s_axis_tvalid <= 1'b0;
		burst_left = 0;
	endtask

	// Waits for every expected point, then lets the block settle.
	task automatic drain();
		stop_stream();
		while (expected_points.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// The enable drops for one cycle after each write.
	task automatic write_reg(input cfg_reg_t idx, input logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_RANGE_MIN: lim_min = val;
			REG_RANGE_MAX: lim_max = val;
			REG_AXIS_X:    ax_r = val;
			REG_AXIS_Y:    ay_r = val;
			REG_AXIS_Z:    az_r = val;
			REG_INC_ANGLE: inc_r = val;
			default: ;
		endcase
	endtask

	task automatic send_load(input int idx, input logic [31:0] val);
		scan_item_t it;
		it = noise_item(OP_LOAD);
		it.idx = 5'(idx);
		it.cval = val;
		send_item(it);
	endtask

	task automatic send_start(input logic [31:0] st, input logic [31:0] sp,
			input logic [31:0] mo);
		scan_item_t it;
		it = noise_item(OP_START);
		it.start_ang = st;
		it.step_ang = sp;
		it.motor_ang = mo;
		send_item(it);
	endtask

	task automatic send_sample(input logic [31:0] rng, input logic last);
		scan_item_t it;
		it = noise_item(OP_SAMPLE);
		it.rng = rng;
		it.last = last;
		send_item(it);
	endtask

	// Mostly modest Q16.16 magnitudes so points stay meaningful, with some
	// raw 32-bit values that drive the saturation paths.
	function automatic logic [31:0] rand_coef();
		if ($urandom_range(0, 7) == 0) return $urandom;
		return $signed($urandom_range(0, 32'h3FFFF)) - 32'sh1FFFF;
	endfunction

	function automatic logic [31:0] rand_range();
		logic [31:0] r;
		r = $urandom >> $urandom_range(0, 31);
		if ($urandom_range(0, 3) != 0 && lim_max >= lim_min)
			r = 32'(lim_min + (r % (lim_max - lim_min + 33'd1)));
		return r;
	endfunction

	task automatic test_coefficient_load();
		// Identity mount and world transforms, then the unused upper slots.
		for (int i = 0; i < 24; i++)
			send_load(i, ((i % 12) / 4 == (i % 4)) ? 32'h0001_0000 : 32'h0);
		for (int i = 24; i < 32; i++)
			send_load(i, $urandom);
	endtask

	task automatic test_directed_points();
		scan_item_t it;
		send_start(32'h0, 32'h0, 32'h0);
		send_sample(32'h0, 1'b0);
		send_sample(32'hFFFF_FFFF, 1'b0);
		send_sample(32'h0001_0000, 1'b1);
		// Extreme angles fold into [-pi, pi); sampling continues afterwards.
		send_start(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_sample(32'h0002_8000, 1'b0);
		send_sample(32'h0002_8000, 1'b0);
		send_sample(32'h7FFF_FFFF, 1'b1);
		send_sample(32'h0000_0001, 1'b0);
		send_start(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
		send_sample(32'h0010_0000, 1'b1);
		// Unused operation code is ignored.
		it = noise_item(OP_NONE);
		send_item(it);
		// Extreme coefficients in the translation slots saturate the result.
		send_load(3, 32'h7FFF_FFFF);
		send_load(15, 32'h8000_0000);
		send_sample(32'hFFFF_FFFF, 1'b1);
		send_load(3, 32'h0);
		send_load(15, 32'h0);
		drain();
		// Narrow window: samples below, inside and above the limits.
		write_reg(REG_RANGE_MIN, 32'h0001_0000);
		write_reg(REG_RANGE_MAX, 32'h0004_0000);
		write_reg(REG_INC_ANGLE, 32'h0100_0000);
		write_reg(REG_AXIS_X, 32'h0);
		write_reg(REG_AXIS_Y, 32'h0);
		write_reg(REG_AXIS_Z, 32'h4000_0000);
		send_start(32'h0800_0000, 32'h0080_0000, 32'h0);
		send_sample(32'h0000_FFFF, 1'b0);
		send_sample(32'h0001_0000, 1'b0);
		send_sample(32'h0004_0000, 1'b0);
		send_sample(32'h0004_0001, 1'b0);
		send_sample(32'h0002_0000, 1'b1);
		drain();
	endtask

	// Random scans with random content, with some noise and broken runs.
	task automatic run_scans(input int n_items);
		int target;
		int len;
		target = items_sent + n_items;
		while (items_sent < target) begin
			case ($urandom_range(0, 9))
				0: send_item(noise_item(OP_NONE));
				1: send_load($urandom_range(0, 31), rand_coef());
				default: begin
					if ($urandom_range(0, 4) != 0)
						send_start($urandom, $urandom, $urandom);
					len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
						: $urandom_range(1, 10);
					for (int i = 0; i < len; i++)
						send_sample(rand_range(),
							(i == len - 1) || ($urandom_range(0, 15) == 0));
				end
			endcase
		end
		drain();
	endtask

	task automatic test_register_settings();
		logic [31:0] axes [4][3];
		axes[0] = '{32'h4000_0000, 32'h0, 32'h0};
		axes[1] = '{32'h0, 32'h4000_0000, 32'h0};
		axes[2] = '{32'h2D41_3CCD, 32'hD2BE_C333, 32'h0};
		axes[3] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF};
		for (int s = 0; s < 4; s++) begin
			write_reg(REG_AXIS_X, axes[s][0]);
			write_reg(REG_AXIS_Y, axes[s][1]);
			write_reg(REG_AXIS_Z, axes[s][2]);
			write_reg(REG_INC_ANGLE, s == 3 ? 32'h8000_0000 : $urandom);
			write_reg(REG_RANGE_MIN, s == 3 ? 32'hFFFF_FFFF : $urandom_range(0, 32'h1_0000));
			write_reg(REG_RANGE_MAX, s == 0 ? 32'hFFFF_FFFF : $urandom);
			run_scans(60);
		end
		write_reg(REG_INC_ANGLE, 32'h7FFF_FFFF);
		write_reg(REG_RANGE_MIN, 32'h0);
		write_reg(REG_RANGE_MAX, 32'h0);
		run_scans(30);
	endtask

	task automatic test_random_stream();
		while (items_sent < ITEM_GOAL) begin
			write_reg(REG_RANGE_MIN, $urandom_range(0, 32'h8000));
			write_reg(REG_RANGE_MAX, $urandom_range(0, 3) == 0 ? $urandom : 32'hFFFF_FFFF);
			write_reg(REG_AXIS_X, $urandom);
			write_reg(REG_AXIS_Y, $urandom);
			write_reg(REG_AXIS_Z, $urandom);
			write_reg(REG_INC_ANGLE, $urandom);
			for (int i = 0; i < 24; i++)
				if ($urandom_range(0, 2) == 0) send_load(i, rand_coef());
			run_scans(120);
		end
	endtask

	// Receiver stall pattern: stretches of full speed, coin-flip and heavy stall.
	int rx_mode;
	int rx_left;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			rx_mode <= 0;
			rx_left <= 0;
		end else begin
			if (rx_left == 0) begin
				rx_mode <= $urandom_range(0, 2);
				rx_left <= $urandom_range(50, 400);
			end else begin
				rx_left <= rx_left - 1;
			end
			case (rx_mode)
				0: m_axis_tready <= 1'b1;
				1: m_axis_tready <= 1'($urandom_range(0, 1));
				default: m_axis_tready <= ($urandom_range(0, 7) == 0);
			endcase
		end
	end

	task automatic report(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch in %s: got %h, expected %h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	// Each accepted point is checked against the oldest expected one.
	always @(posedge clk) begin
		point_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_points.size() == 0) begin
				$display("unexpected point %h at %0t", m_axis_tdata, $realtime);
				errors++;
			end else begin
				want = expected_points.pop_front();
				if (m_axis_tdata[31:0] !== want.x) report("point_x", m_axis_tdata[31:0], want.x);
				if (m_axis_tdata[63:32] !== want.y) report("point_y", m_axis_tdata[63:32], want.y);
				if (m_axis_tdata[95:64] !== want.z) report("point_z", m_axis_tdata[95:64], want.z);
				if (m_axis_tuser[0] !== want.valid)
					report("point_valid", 32'(m_axis_tuser[0]), 32'(want.valid));
				if (m_axis_tlast !== want.last)
					report("last_point", 32'(m_axis_tlast), 32'(want.last));
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_RANGE_MIN;
		cfg_data <= 32'h0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		s_axis_tuser <= OP_NONE;
		s_axis_tlast <= 1'b0;
		errors = 0;
		items_sent = 0;
		burst_left = 0;
		foreach (coef_mem[i]) coef_mem[i] = 32'h0;
		beam_ang = 0;
		beam_inc = 0;
		motor_ang = 0;
		lim_min = 32'h0;
		lim_max = 32'hFFFF_FFFF;
		ax_r = 32'h4000_0000;
		ay_r = 32'h0;
		az_r = 32'h0;
		inc_r = 32'h0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_coefficient_load();
		test_directed_points();
		test_register_settings();
		test_random_stream();

		drain();
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// ----- files.f -----
hw/rtl/stpt_pkg.sv
hw/rtl/stpt_cordic.sv
hw/rtl/stpt_datapath.sv
hw/rtl/stpt_ctrl.sv
hw/rtl/scan_to_point_transform_unit.sv
hw/rtl/stpt_checker.sv
tb/sv/testbench.sv
